// ===== src/psg_pkg.sv =====
// Package for the three-tone, one-noise sound generator.
// Holds register indexes, reset values and the attenuation table.
// No dependencies.
package psg_pkg;

  localparam int unsigned TONE_CH = 3;
  localparam int unsigned VOL_CH  = 4;

  // configuration register indexes
  localparam logic [0:0] CFG_TAP_PATTERN = 1'b0;
  localparam logic [0:0] CFG_SHIFT_LEN   = 1'b1;

  localparam logic [15:0] TAP_PATTERN_RST = 16'h0009;
  localparam logic [4:0]  SHIFT_LEN_RST   = 5'd16;
  localparam logic [15:0] SHIFTER_SEED    = 16'h8000;
  localparam logic [15:0] TAPS_RST        = 16'h9000;

  localparam logic [14:0] NOISE_PER_0   = 15'h0200;
  localparam logic [14:0] NOISE_PER_1   = 15'h0400;
  localparam logic [14:0] NOISE_PER_2   = 15'h0800;
  localparam logic [14:0] NOISE_PER_MIN = 15'd16;
  localparam logic [13:0] MUTE_PERIOD   = 14'd128;

  // latch channel code for the noise channel
  localparam logic [1:0] CH_NOISE = 2'd3;

  typedef logic [13:0] period_t;
  typedef logic [6:0]  vol_t;

  function automatic vol_t atten(input logic [3:0] code);
    vol_t v;
    unique case (code)
      4'd0:  v = 7'd64;
      4'd1:  v = 7'd50;
      4'd2:  v = 7'd39;
      4'd3:  v = 7'd31;
      4'd4:  v = 7'd24;
      4'd5:  v = 7'd19;
      4'd6:  v = 7'd15;
      4'd7:  v = 7'd12;
      4'd8:  v = 7'd9;
      4'd9:  v = 7'd7;
      4'd10: v = 7'd5;
      4'd11: v = 7'd4;
      4'd12: v = 7'd3;
      4'd13: v = 7'd2;
      4'd14: v = 7'd1;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [7:0] tone_lvl(input vol_t vol, input period_t per,
                                                 input logic phase);
    logic signed [7:0] v;
    v = $signed({1'b0, vol});
    if (vol == 7'd0 || per <= MUTE_PERIOD) return 8'sd0;
    return phase ? v : -v;
  endfunction

endpackage

// ===== src/psg_three_tone_one_noise.sv =====
// Top level of the three-tone, one-noise sound generator.
// Depends on psg_pkg.
//
//  channel | signals                                  | role
//  cmd     | cmd_valid, cmd_ready, func, data         | tick or port byte in
//  lvl     | lvl_valid, lvl_ready, tone0..2_level,    | levels out
//          | noise_level, mix_level                   |
//  cfg     | cfg_we, cfg_index, cfg_wdata             | register write
//
// One request per cycle while lvl is not stalled; a request passes the request register,
// then the state update and the result register take it in the same edge.
// Reset (rst, synchronous) puts the generator state at its power-up values.
// A stalled lvl channel holds the result and back-pressures cmd once the
// request register is also full.
module psg_three_tone_one_noise (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic              func,
  input  logic [7:0]        data,
  output logic              lvl_valid,
  input  logic              lvl_ready,
  output logic signed [7:0] tone0_level,
  output logic signed [7:0] tone1_level,
  output logic signed [7:0] tone2_level,
  output logic signed [7:0] noise_level,
  output logic signed [9:0] mix_level,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import psg_pkg::*;

  logic        s1_valid;
  logic        s1_func;
  logic [7:0]  s1_data;
  logic        s1_go;

  logic [15:0] tap_pattern;
  logic [4:0]  shift_len;

  logic [7:0]  command_latch;
  period_t     tone_period    [TONE_CH];
  logic        tone_phase     [TONE_CH];
  period_t     tone_countdown [TONE_CH];
  vol_t        channel_volume [VOL_CH];
  logic [1:0]  noise_rate_select;
  logic [14:0] noise_countdown;
  logic [15:0] noise_shifter;
  logic [15:0] noise_taps_active;

  logic [7:0]  command_latch_next;
  period_t     tone_period_next    [TONE_CH];
  logic        tone_phase_next     [TONE_CH];
  period_t     tone_countdown_next [TONE_CH];
  vol_t        channel_volume_next [VOL_CH];
  logic [1:0]  noise_rate_select_next;
  logic [14:0] noise_countdown_next;
  logic [15:0] noise_shifter_next;
  logic [15:0] noise_taps_active_next;

  logic [15:0] pat_eff;
  logic [4:0]  w_eff;
  logic [15:0] taps_white;
  logic [15:0] taps_looped;
  logic [14:0] noise_per;
  logic [1:0]  ch_idx;

  logic signed [7:0] lvl_n [VOL_CH];
  logic signed [9:0] mix_n;

  assign s1_go     = s1_valid && (!lvl_valid || lvl_ready);
  assign cmd_ready = !s1_valid || s1_go;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ready) begin
      s1_valid <= cmd_valid;
    end
    if (cmd_valid && cmd_ready) begin
      s1_func <= func;
      s1_data <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_pattern <= TAP_PATTERN_RST;
      shift_len   <= SHIFT_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAP_PATTERN: tap_pattern <= cfg_wdata;
        CFG_SHIFT_LEN:   shift_len   <= cfg_wdata[4:0];
      endcase
    end
  end

  // tap reversal into Galois form
  always_comb begin
    if (tap_pattern == 16'd0 || shift_len == 5'd0) begin
      pat_eff = TAP_PATTERN_RST;
      w_eff   = 5'd16;
    end else begin
      pat_eff = tap_pattern;
      w_eff   = (shift_len > 5'd16) ? 5'd16 : shift_len;
    end
    taps_white = 16'd0;
    for (int j = 0; j < 16; j++) begin
      if (5'(j) < w_eff) taps_white[j] = pat_eff[4'(w_eff - 5'd1 - 5'(j))];
    end
    taps_looped = 16'h0001 << 4'(w_eff - 5'd1);
  end

  always_comb begin
    unique case (noise_rate_select)
      2'd0: noise_per = NOISE_PER_0;
      2'd1: noise_per = NOISE_PER_1;
      2'd2: noise_per = NOISE_PER_2;
      default: begin
        noise_per = {tone_period[2], 1'b0};
        if (noise_per == 15'd0) noise_per = NOISE_PER_MIN;
      end
    endcase
  end

  // next generator state
  always_comb begin
    command_latch_next     = command_latch;
    tone_period_next       = tone_period;
    tone_phase_next        = tone_phase;
    tone_countdown_next    = tone_countdown;
    channel_volume_next    = channel_volume;
    noise_rate_select_next = noise_rate_select;
    noise_countdown_next   = noise_countdown;
    noise_shifter_next     = noise_shifter;
    noise_taps_active_next = noise_taps_active;
    ch_idx                 = 2'd0;
    if (s1_func) begin
      if (s1_data[7]) command_latch_next = s1_data;
      ch_idx = command_latch_next[6:5];
      if (command_latch_next[4]) begin
        channel_volume_next[ch_idx] = atten(s1_data[3:0]);
      end else if (ch_idx != CH_NOISE) begin
        if (s1_data[7]) tone_period_next[ch_idx][7:0] = {s1_data[3:0], 4'd0};
        else            tone_period_next[ch_idx][13:8] = s1_data[5:0];
      end else begin
        noise_rate_select_next = s1_data[1:0];
        noise_taps_active_next = s1_data[2] ? taps_white : taps_looped;
        noise_shifter_next     = SHIFTER_SEED;
      end
    end else begin
      for (int c = 0; c < TONE_CH; c++) begin
        if (tone_period[c] == 14'd0) begin
          tone_countdown_next[c] = 14'd0;
        end else if (tone_countdown[c] == 14'd0) begin
          tone_phase_next[c]     = !tone_phase[c];
          tone_countdown_next[c] = tone_period[c] - 14'd1;
        end else begin
          tone_countdown_next[c] = tone_countdown[c] - 14'd1;
        end
      end
      if (channel_volume[3] == 7'd0) begin
        noise_countdown_next = 15'd0;
      end else if (noise_countdown == 15'd0) begin
        noise_shifter_next   = (noise_shifter[0] ? noise_taps_active : 16'd0)
                               ^ (noise_shifter >> 1);
        noise_countdown_next = noise_per - 15'd1;
      end else begin
        noise_countdown_next = noise_countdown - 15'd1;
      end
    end
  end

  // levels from the updated state
  always_comb begin
    for (int c = 0; c < TONE_CH; c++) begin
      lvl_n[c] = tone_lvl(channel_volume_next[c], tone_period_next[c], tone_phase_next[c]);
    end
    lvl_n[3] = noise_shifter_next[0] ? -$signed({1'b0, channel_volume_next[3]})
                                     :  $signed({1'b0, channel_volume_next[3]});
    mix_n = 10'(lvl_n[0]) + 10'(lvl_n[1]) + 10'(lvl_n[2]) + 10'(lvl_n[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_latch     <= 8'd0;
      noise_rate_select <= 2'd0;
      noise_countdown   <= 15'd0;
      noise_shifter     <= SHIFTER_SEED;
      noise_taps_active <= TAPS_RST;
      for (int c = 0; c < TONE_CH; c++) begin
        tone_period[c]    <= 14'd0;
        tone_phase[c]     <= 1'b0;
        tone_countdown[c] <= 14'd0;
      end
      for (int c = 0; c < VOL_CH; c++) begin
        channel_volume[c] <= 7'd0;
      end
    end else if (s1_go) begin
      command_latch     <= command_latch_next;
      tone_period       <= tone_period_next;
      tone_phase        <= tone_phase_next;
      tone_countdown    <= tone_countdown_next;
      channel_volume    <= channel_volume_next;
      noise_rate_select <= noise_rate_select_next;
      noise_countdown   <= noise_countdown_next;
      noise_shifter     <= noise_shifter_next;
      noise_taps_active <= noise_taps_active_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_valid <= 1'b0;
    end else if (s1_go) begin
      lvl_valid <= 1'b1;
    end else if (lvl_ready) begin
      lvl_valid <= 1'b0;
    end
    if (s1_go) begin
      tone0_level <= lvl_n[0];
      tone1_level <= lvl_n[1];
      tone2_level <= lvl_n[2];
      noise_level <= lvl_n[3];
      mix_level   <= mix_n;
    end
  end

`ifndef SYNTHESIS
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> (s1_valid && lvl_valid && !lvl_ready))
    else $error("request stalled without a blocked result");

  a_mix_sum: assert property (@(posedge clk) disable iff (rst)
    lvl_valid |-> mix_level == 10'(tone0_level) + 10'(tone1_level)
                               + 10'(tone2_level) + 10'(noise_level))
    else $error("mix level is not the sum of the channels");

  a_noise_idle: assert property (@(posedge clk) disable iff (rst)
    (s1_go && !s1_func && channel_volume[3] == 7'd0) |=> noise_countdown == 15'd0)
    else $error("silent noise channel kept counting");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !s1_go |=> $stable(noise_shifter) && $stable(command_latch))
    else $error("generator state moved without a request");
`endif

endmodule

// ===== tb/psg_three_tone_one_noise_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for psg_three_tone_one_noise: directed and random request
// streams, random stalls on both channels, levels checked against a local predictor.
// Depends on psg_pkg and the generator RTL.
module psg_three_tone_one_noise_test;
  import psg_pkg::*;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [1:0] RATE_512   = 2'd0;
  localparam logic [1:0] RATE_1024  = 2'd1;
  localparam logic [1:0] RATE_2048  = 2'd2;
  localparam logic [1:0] RATE_TONE2 = 2'd3;

  localparam logic [1:0] CH_TONE0 = 2'd0;
  localparam logic [1:0] CH_TONE1 = 2'd1;
  localparam logic [1:0] CH_TONE2 = 2'd2;

  // attenuation steps, code 0 in the low slice
  localparam logic [16*7-1:0] ATTEN_STEPS = {7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd7,
    7'd9, 7'd12, 7'd15, 7'd19, 7'd24, 7'd31, 7'd39, 7'd50, 7'd64};

  typedef struct packed {
    logic signed [7:0] tone0;
    logic signed [7:0] tone1;
    logic signed [7:0] tone2;
    logic signed [7:0] noise;
    logic signed [9:0] mix;
  } levels_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_ready;
  logic              func = 1'b0;
  logic [7:0]        data = 8'h00;
  logic              lvl_valid;
  logic              lvl_ready = 1'b0;
  logic signed [7:0] tone0_level;
  logic signed [7:0] tone1_level;
  logic signed [7:0] tone2_level;
  logic signed [7:0] noise_level;
  logic signed [9:0] mix_level;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = CFG_TAP_PATTERN;
  logic [15:0]       cfg_wdata = 16'h0000;

  psg_three_tone_one_noise dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .func(func), .data(data),
    .lvl_valid(lvl_valid), .lvl_ready(lvl_ready),
    .tone0_level(tone0_level), .tone1_level(tone1_level), .tone2_level(tone2_level),
    .noise_level(noise_level), .mix_level(mix_level),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] tap_cfg;
  logic [4:0]  width_cfg;
  logic [7:0]  latch_q;
  logic [13:0] period_q [3];
  logic        phase_q [3];
  logic [13:0] count_q [3];
  logic [6:0]  vol_q [4];
  logic [1:0]  rate_q;
  logic [14:0] noise_count_q;
  logic [15:0] shifter_q;
  logic [15:0] taps_q;

  levels_t pending_levels [$];
  int      level_errors = 0;
  int      requests_sent = 0;
  bit      idling = 1'b1;

  function automatic logic [6:0] step_volume(input logic [3:0] code);
    return ATTEN_STEPS[code*7 +: 7];
  endfunction

  function automatic void reset_generator();
    tap_cfg = TAP_PATTERN_RST;
    width_cfg = SHIFT_LEN_RST;
    latch_q = 8'h00;
    for (int ch = 0; ch < 3; ch++) begin
      period_q[ch] = '0;
      phase_q[ch] = 1'b0;
      count_q[ch] = '0;
    end
    for (int ch = 0; ch < 4; ch++) vol_q[ch] = '0;
    rate_q = RATE_512;
    noise_count_q = '0;
    shifter_q = SHIFTER_SEED;
    taps_q = TAPS_RST;
  endfunction

  function automatic void predict_request(input logic f, input logic [7:0] d);
    levels_t     lv;
    int          lvl [4];
    int          sum;
    int          w;
    logic [1:0]  idx;
    logic [14:0] per;
    logic [15:0] pat;
    logic [15:0] white;
    logic [15:0] looped;
    if (f == FUNC_WRITE) begin
      if (d[7]) latch_q = d;
      idx = latch_q[6:5];
      if (latch_q[4]) begin
        vol_q[idx] = step_volume(d[3:0]);
      end else if (idx != CH_NOISE) begin
        if (d[7]) period_q[idx] = {period_q[idx][13:8], d[3:0], 4'h0};
        else period_q[idx] = {d[5:0], period_q[idx][7:0]};
      end else begin
        pat = tap_cfg;
        w = width_cfg;
        if (pat == 16'h0 || w == 0) begin
          pat = TAP_PATTERN_RST;
          w = SHIFT_LEN_RST;
        end
        if (w > 16) w = 16;
        white = '0;
        for (int i = 0; i < w; i++) begin
          white = {white[14:0], pat[0]};
          pat = pat >> 1;
        end
        looped = 16'h1 << (w - 1);
        rate_q = d[1:0];
        taps_q = d[2] ? white : looped;
        shifter_q = SHIFTER_SEED;
      end
    end else begin
      for (int ch = 0; ch < 3; ch++) begin
        if (period_q[ch] == '0) begin
          count_q[ch] = '0;
        end else if (count_q[ch] == '0) begin
          phase_q[ch] = ~phase_q[ch];
          count_q[ch] = period_q[ch] - 14'd1;
        end else begin
          count_q[ch] = count_q[ch] - 14'd1;
        end
      end
      if (vol_q[3] == '0) begin
        noise_count_q = '0;
      end else if (noise_count_q == '0) begin
        case (rate_q)
          RATE_512:  per = NOISE_PER_0;
          RATE_1024: per = NOISE_PER_1;
          RATE_2048: per = NOISE_PER_2;
          default: begin
            per = {period_q[2], 1'b0};
            if (per == '0) per = NOISE_PER_MIN;
          end
        endcase
        shifter_q = (shifter_q[0] ? taps_q : 16'h0) ^ (shifter_q >> 1);
        noise_count_q = per - 15'd1;
      end else begin
        noise_count_q = noise_count_q - 15'd1;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (vol_q[ch] == '0 || period_q[ch] <= MUTE_PERIOD) lvl[ch] = 0;
      else lvl[ch] = phase_q[ch] ? int'(vol_q[ch]) : -int'(vol_q[ch]);
    end
    lvl[3] = shifter_q[0] ? -int'(vol_q[3]) : int'(vol_q[3]);
    sum = lvl[0] + lvl[1] + lvl[2] + lvl[3];
    lv.tone0 = 8'(lvl[0]);
    lv.tone1 = 8'(lvl[1]);
    lv.tone2 = 8'(lvl[2]);
    lv.noise = 8'(lvl[3]);
    lv.mix = 10'(sum);
    pending_levels.push_back(lv);
  endfunction

  // valid stays high from one request to the next; it drops for a gap or in wait_drained
  task automatic send_request(input logic f, input logic [7:0] d);
    int gap;
    gap = 0;
    while (idling && $urandom_range(99) < 38) gap++;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    func <= f;
    data <= d;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    predict_request(f, d);
    requests_sent++;
  endtask

  task automatic send_tick();
    send_request(FUNC_TICK, 8'($urandom));
  endtask

  task automatic send_volume(input logic [1:0] ch, input logic [3:0] code);
    send_request(FUNC_WRITE, {1'b1, ch, 1'b1, code});
  endtask

  task automatic send_period(input logic [1:0] ch, input logic [9:0] p);
    send_request(FUNC_WRITE, {1'b1, ch, 1'b0, p[3:0]});
    send_request(FUNC_WRITE, {1'b0, 1'($urandom), p[9:4]});
  endtask

  task automatic send_noise_control(input logic white, input logic [1:0] rate);
    send_request(FUNC_WRITE, {1'b1, CH_NOISE, 1'b0, 1'($urandom), white, rate});
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [0:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_TAP_PATTERN) tap_cfg = value;
    else width_cfg = value[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(FUNC_TICK, 8'hFF);
    send_volume(CH_TONE0, 4'h0);
    send_request(FUNC_WRITE, 8'h8F);
    send_request(FUNC_WRITE, 8'h3F);         // tone 0 at the longest period
    send_request(FUNC_WRITE, 8'hC8);         // tone 2 right on the mute threshold
    send_volume(CH_TONE2, 4'h1);
    send_tick();
    send_request(FUNC_WRITE, 8'hC9);         // one step above it
    send_tick();
    send_request(FUNC_WRITE, 8'hA0);         // tone 1 period zero holds phase
    send_volume(CH_TONE1, 4'h5);
    send_tick();
    send_volume(CH_NOISE, 4'hF);
    send_request(FUNC_WRITE, 8'h0E);         // volume via data byte
    send_request(FUNC_WRITE, 8'hC0);
    send_request(FUNC_WRITE, 8'h40);         // tone 2 back to zero: noise rate 16
    send_noise_control(1'b1, RATE_TONE2);
    send_volume(CH_NOISE, 4'h0);
    repeat (4) send_tick();
    send_noise_control(1'b0, RATE_512);
    send_request(FUNC_WRITE, 8'h06);         // noise control via data byte
    send_tick();
  endtask

  task automatic test_random_music(input int count);
    int r;
    int stop_at;
    int next_drain;
    stop_at = requests_sent + count;
    next_drain = requests_sent + 150;
    while (requests_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 50) repeat ($urandom_range(1, 12)) send_tick();
      else if (r < 62) send_volume(2'($urandom), 4'($urandom));
      else if (r < 78)
        send_period(2'($urandom_range(2)),
                    ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(24)));
      else if (r < 84) send_noise_control(1'($urandom), 2'($urandom));
      else if (r < 90) send_request(FUNC_WRITE, {1'b0, 7'($urandom)});
      else send_request(FUNC_WRITE, 8'($urandom));
      if (requests_sent >= next_drain) begin
        wait_drained();
        next_drain = requests_sent + 150;
      end
    end
  endtask

  task automatic test_without_stalls(input int count);
    idling = 1'b0;
    test_random_music(count);
    wait_drained();
    idling = 1'b1;
  endtask

  task automatic test_tap_settings();
    logic [15:0] pats [7];
    logic [4:0]  widths [7];
    pats = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8001, 16'hB400, 16'hFFFF, 16'($urandom)};
    widths = '{5'd16, 5'd16, 5'd1, 5'd31, 5'd0, 5'd15, 5'($urandom_range(1, 16))};
    for (int s = 0; s < 7; s++) begin
      wait_drained();
      write_register(CFG_TAP_PATTERN, pats[s]);
      write_register(CFG_SHIFT_LEN, {11'h0, widths[s]});
      send_volume(CH_NOISE, 4'($urandom_range(14)));
      send_period(CH_TONE2, 10'($urandom_range(2)));
      send_noise_control(1'b1, RATE_TONE2);
      repeat (20) send_tick();
      send_noise_control(1'b0, RATE_TONE2);
      repeat (20) send_tick();
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    lvl_ready <= !idling || ($urandom_range(99) >= 38);
  end

  function automatic void check_field(input string name, input logic signed [9:0] want,
                                      input logic signed [9:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      level_errors++;
    end
  endfunction

  always @(posedge clk) begin : check_levels
    levels_t want;
    if (!rst && lvl_valid && lvl_ready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: levels with no request outstanding, mix %0d", $time, mix_level);
        level_errors++;
      end else begin
        want = pending_levels.pop_front();
        check_field("tone0_level", want.tone0, tone0_level);
        check_field("tone1_level", want.tone1, tone1_level);
        check_field("tone2_level", want.tone2, tone2_level);
        check_field("noise_level", want.noise, noise_level);
        check_field("mix_level", want.mix, mix_level);
      end
    end
  end

  initial begin
    reset_generator();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_music(700);
    test_tap_settings();
    test_without_stalls(200);
    wait_drained();
    if (level_errors == 0 && pending_levels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
